FILE: rtl/core/tdcc_pkg.sv
// Shared types, codes and quantizer tables of the timed duty-cycle controller.
package tdcc_pkg;

  // Field widths
  localparam int unsigned OpW        = 2;
  localparam int unsigned LevelW     = 10;
  localparam int unsigned LimitW     = 10;
  localparam int unsigned PeriodW    = 5;
  localparam int unsigned RateW      = 5;
  localparam int unsigned MinutesW   = 8;
  localparam int unsigned SecondsW   = 14;
  localparam int unsigned BoostCntW  = 10;
  localparam int unsigned DurCodeW   = 3;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 10;

  // Register reset values
  localparam logic [LimitW-1:0]  BoostLimitReset  = 10'd600;
  localparam logic [PeriodW-1:0] CyclePeriodReset = 5'd20;

  // Register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_BOOST_LIMIT  = 1'b0,
    CFG_CYCLE_PERIOD = 1'b1
  } cfg_idx_t;

  // Event kinds
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_BOOST  = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  // Duration selection codes
  typedef enum logic [DurCodeW-1:0] {
    DUR_NONE = 3'd0,
    DUR_10M  = 3'd1,
    DUR_30M  = 3'd2,
    DUR_60M  = 3'd3,
    DUR_120M = 3'd4,
    DUR_240M = 3'd5
  } dur_code_t;

  // Controller state
  typedef struct packed {
    logic                 run;
    logic                 boost;
    logic [BoostCntW-1:0] boost_sec;
    logic [SecondsW-1:0]  run_sec;
    logic [PeriodW-1:0]   phase;
    logic [RateW-1:0]     rate;
    dur_code_t            dur;
    logic [RateW-1:0]     on_time;
    logic                 ozone;
  } tdcc_state_t;

  // Map rate pot reading to grams per hour
  function automatic logic [RateW-1:0] quant_rate(input logic [LevelW-1:0] v);
    logic [RateW-1:0] r;
    if (v >= 10'd853)      r = 5'd20;
    else if (v >= 10'd683) r = 5'd10;
    else if (v >= 10'd513) r = 5'd5;
    else if (v >= 10'd343) r = 5'd2;
    else if (v >= 10'd170) r = 5'd1;
    else                   r = 5'd0;
    return r;
  endfunction

  // Map duration pot reading to a duration code
  function automatic dur_code_t quant_dur(input logic [LevelW-1:0] v);
    dur_code_t d;
    if (v >= 10'd853)      d = DUR_240M;
    else if (v >= 10'd683) d = DUR_120M;
    else if (v >= 10'd513) d = DUR_60M;
    else if (v >= 10'd343) d = DUR_30M;
    else if (v >= 10'd173) d = DUR_10M;
    else                   d = DUR_NONE;
    return d;
  endfunction

  function automatic logic [MinutesW-1:0] dur_minutes(input dur_code_t d);
    logic [MinutesW-1:0] m;
    case (d)
      DUR_10M:  m = 8'd10;
      DUR_30M:  m = 8'd30;
      DUR_60M:  m = 8'd60;
      DUR_120M: m = 8'd120;
      DUR_240M: m = 8'd240;
      default:  m = 8'd0;
    endcase
    return m;
  endfunction

  function automatic logic [SecondsW-1:0] dur_seconds(input dur_code_t d);
    logic [SecondsW-1:0] s;
    case (d)
      DUR_10M:  s = 14'(10 * 60);
      DUR_30M:  s = 14'(30 * 60);
      DUR_60M:  s = 14'(60 * 60);
      DUR_120M: s = 14'(120 * 60);
      DUR_240M: s = 14'(240 * 60);
      default:  s = 14'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/tdcc_step.sv
// Next-state logic for one event of the timed duty-cycle controller.
module tdcc_step
  import tdcc_pkg::*;
(
  input  tdcc_state_t         cur,
  input  op_t                 op,
  input  logic [LevelW-1:0]   power_level,
  input  logic [LevelW-1:0]   duration_level,
  input  logic [LimitW-1:0]   boost_limit,
  input  logic [PeriodW-1:0]  cycle_period,
  output tdcc_state_t         nxt
);

  logic [PeriodW:0] phase_inc;

  always_comb begin
    nxt       = cur;
    phase_inc = {1'b0, cur.phase} + 1'b1;

    // Apply the event
    case (op)
      OP_TICK: begin
        if (cur.run) begin
          if (cur.run_sec != '1) nxt.run_sec = cur.run_sec + 1'b1;
          if (cur.boost) begin
            if (cur.boost_sec != '1) nxt.boost_sec = cur.boost_sec + 1'b1;
            nxt.ozone = 1'b1;
          end else begin
            nxt.ozone = (cur.phase < cur.on_time);
            if (phase_inc >= {1'b0, cycle_period}) nxt.phase = '0;
            else                                   nxt.phase = phase_inc[PeriodW-1:0];
          end
        end
      end
      OP_START: begin
        nxt.boost_sec = '0;
        if (!cur.run && cur.rate != '0 && cur.dur != DUR_NONE) begin
          nxt.on_time = cur.rate;
          nxt.run     = 1'b1;
        end else if (cur.run) begin
          nxt.run     = 1'b0;
          nxt.ozone   = 1'b0;
          nxt.boost   = 1'b0;
          nxt.run_sec = '0;
        end
      end
      OP_BOOST: begin
        if (!cur.boost) begin
          nxt.boost     = 1'b1;
          nxt.boost_sec = '0;
        end else begin
          nxt.boost = 1'b0;
        end
      end
      default: begin
        if (!cur.run) begin
          nxt.rate = quant_rate(power_level);
          nxt.dur  = quant_dur(duration_level);
        end
      end
    endcase

    // End the run once its length is reached
    if (nxt.run && nxt.run_sec >= dur_seconds(nxt.dur)) begin
      nxt.boost_sec = '0;
      nxt.run       = 1'b0;
      nxt.ozone     = 1'b0;
      nxt.boost     = 1'b0;
      nxt.run_sec   = '0;
    end

    // Drop boost once its count passes the limit
    if (nxt.boost && nxt.run && nxt.boost_sec > boost_limit) nxt.boost = 1'b0;
  end

endmodule

FILE: rtl/core/timed_duty_cycle_controller.sv
// Top level of the timed duty-cycle controller: input stage, state and result register.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_op, in_power_level, in_duration_level
//   out_     output     out_valid / out_ready   out_ozone_on .. out_elapsed_seconds
//   cfg_     input      cfg_we (no wait)        cfg_index, cfg_wdata
//
// One event per clock when out_ready stays high; each accepted beat passes through
// the input register, then the state update and result register in one pass through
// the next-state logic. Synchronous active-low reset clears the state and both valid
// flags and loads the configuration registers with their reset values.
// A stalled output holds its beat; the input register keeps taking beats until
// both stages are full.
module timed_duty_cycle_controller
  import tdcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OpW-1:0]       in_op,
  input  logic [LevelW-1:0]    in_power_level,
  input  logic [LevelW-1:0]    in_duration_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ozone_on,
  output logic                 out_fan_on,
  output logic                 out_running,
  output logic                 out_boost_on,
  output logic [RateW-1:0]     out_rate_grams,
  output logic [MinutesW-1:0]  out_duration_minutes,
  output logic [SecondsW-1:0]  out_elapsed_seconds,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  logic [LimitW-1:0]  boost_limit_r;
  logic [PeriodW-1:0] cycle_period_r;

  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [LevelW-1:0]  s1_pwr_r;
  logic [LevelW-1:0]  s1_dur_r;
  logic               s1_adv;

  tdcc_state_t        st_r;
  tdcc_state_t        st_nxt;

  logic               out_valid_r;
  logic               ozone_r;
  logic               run_r;
  logic               boost_r;
  logic [RateW-1:0]   rate_r;
  logic [MinutesW-1:0] minutes_r;
  logic [SecondsW-1:0] elapsed_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_limit_r  <= BoostLimitReset;
      cycle_period_r <= CyclePeriodReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BOOST_LIMIT:  boost_limit_r  <= cfg_wdata[LimitW-1:0];
        CFG_CYCLE_PERIOD: cycle_period_r <= cfg_wdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= op_t'(in_op);
      s1_pwr_r <= in_power_level;
      s1_dur_r <= in_duration_level;
    end
  end

  tdcc_step u_step (
    .cur            (st_r),
    .op             (s1_op_r),
    .power_level    (s1_pwr_r),
    .duration_level (s1_dur_r),
    .boost_limit    (boost_limit_r),
    .cycle_period   (cycle_period_r),
    .nxt            (st_nxt)
  );

  // Advance the controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ozone_r   <= st_nxt.ozone;
      run_r     <= st_nxt.run;
      boost_r   <= st_nxt.boost;
      rate_r    <= st_nxt.rate;
      minutes_r <= dur_minutes(st_nxt.dur);
      elapsed_r <= st_nxt.run_sec;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ozone_on         = ozone_r;
  assign out_fan_on           = run_r;
  assign out_running          = run_r;
  assign out_boost_on         = boost_r;
  assign out_rate_grams       = rate_r;
  assign out_duration_minutes = minutes_r;
  assign out_elapsed_seconds  = elapsed_r;

  // Generator is never on outside a run
  a_ozone_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ozone |-> st_r.run)
    else $error("generator on while idle");

  // Elapsed time is cleared whenever no run is in progress
  a_idle_elapsed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.run |-> (st_r.run_sec == '0))
    else $error("elapsed time nonzero while idle");

  // A run only exists with a nonzero selection
  a_run_has_selection: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.run |-> (st_r.rate != '0 && st_r.dur != DUR_NONE))
    else $error("run active with empty selection");

  // Every advanced beat shows up in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat lost");

  // A waiting result is not overwritten by the next beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_adv)
    else $error("result overwritten while stalled");

endmodule

FILE: test/timed_duty_cycle_controller_tb.sv
// Testbench for the timed duty-cycle controller: event stimulus, status prediction and checking.
module timed_duty_cycle_controller_tb
  import tdcc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Expected status beat, one per event
  typedef struct packed {
    logic                ozone;
    logic                fan;
    logic                running;
    logic                boost;
    logic [RateW-1:0]    rate;
    logic [MinutesW-1:0] minutes;
    logic [SecondsW-1:0] elapsed;
  } ctl_status_t;

  localparam int unsigned RandomEvents = 12;
  localparam int unsigned RandomPhases = 3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OpW-1:0]       in_op = OP_TICK;
  logic [LevelW-1:0]    in_power_level = '0;
  logic [LevelW-1:0]    in_duration_level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_ozone_on;
  logic                 out_fan_on;
  logic                 out_running;
  logic                 out_boost_on;
  logic [RateW-1:0]     out_rate_grams;
  logic [MinutesW-1:0]  out_duration_minutes;
  logic [SecondsW-1:0]  out_elapsed_seconds;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = CFG_BOOST_LIMIT;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  timed_duty_cycle_controller u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_power_level       (in_power_level),
    .in_duration_level    (in_duration_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_ozone_on         (out_ozone_on),
    .out_fan_on           (out_fan_on),
    .out_running          (out_running),
    .out_boost_on         (out_boost_on),
    .out_rate_grams       (out_rate_grams),
    .out_duration_minutes (out_duration_minutes),
    .out_elapsed_seconds  (out_elapsed_seconds),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted controller state and register copies
  bit                  run_st;
  bit                  boost_st;
  bit [BoostCntW-1:0]  boost_cnt;
  bit [SecondsW-1:0]   elapsed_st;
  bit [PeriodW-1:0]    phase_st;
  bit [RateW-1:0]      rate_st;
  bit [SecondsW-1:0]   run_len_st;
  bit [RateW-1:0]      on_time_st;
  bit                  ozone_st;
  bit [LimitW-1:0]     boost_limit_reg = BoostLimitReset;
  bit [PeriodW-1:0]    cycle_period_reg = CyclePeriodReset;

  ctl_status_t pending_status[$];

  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned effective_events;
  int unsigned beats_checked;
  int unsigned runs_timed_out;
  int unsigned boosts_expired;
  int unsigned burst_left;
  int unsigned rcv_cyc;
  bit          steady;

  // Random pot reading in a range
  function automatic bit [LevelW-1:0] rand_level(int unsigned lo, int unsigned hi);
    return LevelW'($urandom_range(lo, hi));
  endfunction

  // Map a rate pot reading to grams
  function automatic bit [RateW-1:0] rate_of_level(bit [LevelW-1:0] v);
    if (v >= 10'd853) return 5'd20;
    if (v >= 10'd683) return 5'd10;
    if (v >= 10'd513) return 5'd5;
    if (v >= 10'd343) return 5'd2;
    if (v >= 10'd170) return 5'd1;
    return 5'd0;
  endfunction

  // Map a duration pot reading to run length in seconds
  function automatic bit [SecondsW-1:0] run_len_of_level(bit [LevelW-1:0] v);
    if (v >= 10'd853) return SecondsW'(240 * 60);
    if (v >= 10'd683) return SecondsW'(120 * 60);
    if (v >= 10'd513) return SecondsW'(60 * 60);
    if (v >= 10'd343) return SecondsW'(30 * 60);
    if (v >= 10'd173) return SecondsW'(10 * 60);
    return '0;
  endfunction

  function automatic void start_or_stop();
    boost_cnt = '0;
    if (!run_st && rate_st != '0 && run_len_st != '0) begin
      on_time_st = rate_st;
      run_st = 1'b1;
    end else if (run_st) begin
      run_st = 1'b0;
      ozone_st = 1'b0;
      boost_st = 1'b0;
      elapsed_st = '0;
    end
  endfunction

  function automatic void flip_boost();
    if (!boost_st) begin
      boost_st = 1'b1;
      boost_cnt = '0;
    end else begin
      boost_st = 1'b0;
    end
  endfunction

  function automatic void second_tick();
    int nxt;
    if (!run_st) return;
    if (elapsed_st != '1) elapsed_st++;
    if (boost_st) begin
      if (boost_cnt != '1) boost_cnt++;
      ozone_st = 1'b1;
      return;
    end
    ozone_st = phase_st < on_time_st;
    nxt = (int'(phase_st) + 1) & 63;
    if (nxt >= int'(cycle_period_reg)) nxt = 0;
    phase_st = nxt[PeriodW-1:0];
  endfunction

  // Apply one event to the predicted state and return the status it leaves
  function automatic ctl_status_t apply_event(op_t op, bit [LevelW-1:0] pwr,
                                              bit [LevelW-1:0] dur);
    ctl_status_t s;
    case (op)
      OP_TICK:  second_tick();
      OP_START: start_or_stop();
      OP_BOOST: flip_boost();
      default: begin
        if (!run_st) begin
          rate_st = rate_of_level(pwr);
          run_len_st = run_len_of_level(dur);
        end
      end
    endcase
    if (run_st && elapsed_st >= run_len_st) begin
      start_or_stop();
      runs_timed_out++;
    end
    if (boost_st && run_st && boost_cnt > boost_limit_reg) begin
      flip_boost();
      boosts_expired++;
    end
    s.ozone   = ozone_st;
    s.fan     = run_st;
    s.running = run_st;
    s.boost   = boost_st;
    s.rate    = rate_st;
    s.minutes = MinutesW'(run_len_st / 60);
    s.elapsed = elapsed_st;
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
                                beats_checked, name, got, want));
  endtask

  // Send one event beat; bursts of random length with random gaps in between
  task automatic send_event(op_t op, bit [LevelW-1:0] pwr, bit [LevelW-1:0] dur);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (steady) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_power_level <= pwr;
    in_duration_level <= dur;
    do @(posedge clk); while (!in_ready);
    if (!((op == OP_TICK && !run_st) || (op == OP_SAMPLE && run_st)))
      effective_events++;
    events_sent++;
    pending_status.push_back(apply_event(op, pwr, dur));
  endtask

  // Drop valid and hold until every pending status has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_BOOST_LIMIT) boost_limit_reg = value[LimitW-1:0];
    else cycle_period_reg = value[PeriodW-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_event(OP_TICK, rand_level(0, 1023), rand_level(0, 1023));
  endtask

  // Check each result beat against the oldest pending status; stall on own pattern
  always @(posedge clk) begin : result_side
    ctl_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result beat with no pending status");
      end else begin
        want = pending_status.pop_front();
        check_field("ozone_on", int'(out_ozone_on), int'(want.ozone));
        check_field("fan_on", int'(out_fan_on), int'(want.fan));
        check_field("running", int'(out_running), int'(want.running));
        check_field("boost_on", int'(out_boost_on), int'(want.boost));
        check_field("rate_grams", int'(out_rate_grams), int'(want.rate));
        check_field("duration_minutes", int'(out_duration_minutes), int'(want.minutes));
        check_field("elapsed_seconds", int'(out_elapsed_seconds), int'(want.elapsed));
        beats_checked++;
      end
    end
    rcv_cyc++;
    if (steady) begin
      out_ready <= 1'b1;
    end else begin
      case ((rcv_cyc / 97) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 3) != 0;
        2:       out_ready <= $urandom_range(0, 9) < 3;
        default: out_ready <= (rcv_cyc % 11) > 3;
      endcase
    end
  end

  // Idle events, quantizer edges and starts with a zero selection
  task automatic test_idle_events();
    send_event(OP_TICK, 10'd0, 10'd0);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_event(OP_START, 10'd0, 10'd0);
    send_event(OP_SAMPLE, 10'd1023, 10'd0);
    send_event(OP_START, 10'd0, 10'd0);
    send_event(OP_SAMPLE, 10'd0, 10'd1023);
    send_event(OP_START, 10'd1023, 10'd1023);
    send_event(OP_SAMPLE, 10'd169, 10'd172);
    send_event(OP_SAMPLE, 10'd170, 10'd173);
    send_event(OP_SAMPLE, 10'd342, 10'd342);
    send_event(OP_SAMPLE, 10'd343, 10'd343);
    send_event(OP_SAMPLE, 10'd512, 10'd512);
    send_event(OP_SAMPLE, 10'd513, 10'd513);
    send_event(OP_SAMPLE, 10'd682, 10'd682);
    send_event(OP_SAMPLE, 10'd683, 10'd683);
    send_event(OP_SAMPLE, 10'd852, 10'd852);
    send_event(OP_SAMPLE, 10'd853, 10'd853);
    send_event(OP_SAMPLE, 10'd1023, 10'd1023);
    send_event(OP_TICK, 10'd1023, 10'd1023);
  endtask

  // Ten-minute run that ends on its own, with a sample ignored mid-run;
  // the first half goes back to back with the receiver always ready
  task automatic test_full_run();
    drain();
    write_reg(CFG_CYCLE_PERIOD, 10'd31);
    send_event(OP_SAMPLE, 10'd1023, 10'd200);
    send_event(OP_START, 10'd0, 10'd0);
    steady = 1'b1;
    send_ticks(300);
    steady = 1'b0;
    send_event(OP_SAMPLE, 10'd0, 10'd1023);
    send_ticks(300);
    send_event(OP_TICK, 10'd0, 10'd0);
  endtask

  // Stop by press, phase kept across runs, period shrunk below the phase
  task automatic test_stop_and_phase();
    drain();
    write_reg(CFG_CYCLE_PERIOD, 10'd20);
    send_event(OP_SAMPLE, 10'd200, 10'd200);
    send_event(OP_START, 10'd0, 10'd0);
    send_ticks(13);
    send_event(OP_START, 10'd0, 10'd0);
    drain();
    write_reg(CFG_CYCLE_PERIOD, 10'd4);
    send_event(OP_SAMPLE, 10'd600, 10'd600);
    send_event(OP_START, 10'd0, 10'd0);
    send_ticks(10);
    send_event(OP_START, 10'd0, 10'd0);
    drain();
    write_reg(CFG_CYCLE_PERIOD, 10'd0);
    send_event(OP_START, 10'd0, 10'd0);
    send_ticks(5);
    send_event(OP_START, 10'd0, 10'd0);
    drain();
    write_reg(CFG_CYCLE_PERIOD, 10'd1);
    send_event(OP_START, 10'd0, 10'd0);
    send_ticks(4);
    send_event(OP_START, 10'd0, 10'd0);
  endtask

  // Boost armed while idle, expiry with the generator held, toggles mid-run
  task automatic test_boost();
    drain();
    write_reg(CFG_BOOST_LIMIT, 10'd1);
    write_reg(CFG_CYCLE_PERIOD, 10'd6);
    send_event(OP_SAMPLE, 10'd700, 10'd1023);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_event(OP_START, 10'd0, 10'd0);
    send_ticks(8);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_ticks(1);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_ticks(2);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_event(OP_START, 10'd0, 10'd0);
    drain();
    write_reg(CFG_BOOST_LIMIT, 10'd1000);
    send_event(OP_START, 10'd0, 10'd0);
    send_event(OP_BOOST, 10'd0, 10'd0);
    send_ticks(20);
    send_event(OP_START, 10'd0, 10'd0);
  endtask

  // Random runs with random content, plus noise, over several register settings
  task automatic test_random();
    int unsigned goal;
    int unsigned n;
    int unsigned pick;
    bit [LevelW-1:0] pwr;
    bit [LevelW-1:0] dur;
    goal = effective_events;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_BOOST_LIMIT, 10'd1);
          write_reg(CFG_CYCLE_PERIOD, 10'd1);
        end
        1: begin
          write_reg(CFG_BOOST_LIMIT, 10'd1000);
          write_reg(CFG_CYCLE_PERIOD, 10'd31);
        end
        default: begin
          write_reg(CFG_BOOST_LIMIT, CfgDataW'(($urandom_range(0, 1) != 0) ?
                                               $urandom_range(1, 40) :
                                               $urandom_range(1, 1000)));
          write_reg(CFG_CYCLE_PERIOD, CfgDataW'($urandom_range(1, 31)));
        end
      endcase
      goal += RandomEvents / RandomPhases;
      while (effective_events < goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // well-formed run: select, maybe arm boost, start, mostly ticks
          pwr = rand_level(170, 1023);
          dur = ($urandom_range(0, 9) < 7) ? rand_level(173, 342) : rand_level(0, 1023);
          send_event(OP_SAMPLE, pwr, dur);
          if ($urandom_range(0, 4) == 0) send_event(OP_BOOST, pwr, dur);
          send_event(OP_START, pwr, dur);
          n = $urandom_range(3, 8);
          repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)      send_event(OP_TICK, rand_level(0, 1023), rand_level(0, 1023));
            else if (pick < 90) send_event(OP_BOOST, rand_level(0, 1023), rand_level(0, 1023));
            else if (pick < 94) send_event(OP_SAMPLE, rand_level(0, 1023), rand_level(0, 1023));
            else if (pick < 97) send_event(OP_START, rand_level(0, 1023), rand_level(0, 1023));
            else send_event(op_t'($urandom_range(0, 3)), rand_level(0, 1023),
                            rand_level(0, 1023));
          end
          if ($urandom_range(0, 1) != 0) send_event(OP_START, 10'd0, 10'd0);
        end else begin
          // noise
          repeat ($urandom_range(1, 6))
            send_event(op_t'($urandom_range(0, 3)), rand_level(0, 1023),
                       rand_level(0, 1023));
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_events();
    test_full_run();
    test_stop_and_phase();
    test_boost();
    test_random();
    drain();
    repeat (4) @(posedge clk);
    $display("Run covered %0d events (%0d with effect), %0d status beats checked.",
             events_sent, effective_events, beats_checked);
    $display("Timed runs ended on their own: %0d; boost periods expired: %0d.",
             runs_timed_out, boosts_expired);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d status beats pending", pending_status.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tdcc_pkg.sv
rtl/core/tdcc_step.sv
rtl/core/timed_duty_cycle_controller.sv
test/timed_duty_cycle_controller_tb.sv
